// ===== hdl/sgrp_pkg.sv =====
// sgr pen attribute parser: shared types, code constants and the per-item update
// rules. used by sgrp_next, sgr_pen_attribute_parser_core and sgrp_checker
// no dependencies
package sgrp_pkg;

  localparam int PARAM_W = 16;
  localparam int OUT_W   = 64;

  // colour kinds
  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_BASIC   = 2'd1;
  localparam logic [1:0] KIND_PALETTE = 2'd2;
  localparam logic [1:0] KIND_RGB     = 2'd3;

  // sgr parameter codes
  localparam logic [15:0] SGR_RESET       = 16'd0;
  localparam logic [15:0] SGR_BOLD        = 16'd1;
  localparam logic [15:0] SGR_ITALIC      = 16'd3;
  localparam logic [15:0] SGR_UNDERLINE   = 16'd4;
  localparam logic [15:0] SGR_BLINK       = 16'd5;
  localparam logic [15:0] SGR_INVERSE     = 16'd7;
  localparam logic [15:0] SGR_STRIKE      = 16'd9;
  localparam logic [15:0] SGR_NO_BOLD_A   = 16'd21;
  localparam logic [15:0] SGR_NO_BOLD_B   = 16'd22;
  localparam logic [15:0] SGR_NO_ITALIC   = 16'd23;
  localparam logic [15:0] SGR_NO_UNDERL   = 16'd24;
  localparam logic [15:0] SGR_NO_BLINK    = 16'd25;
  localparam logic [15:0] SGR_NO_INVERSE  = 16'd27;
  localparam logic [15:0] SGR_FG_BASE     = 16'd30;
  localparam logic [15:0] SGR_FG_TOP      = 16'd37;
  localparam logic [15:0] SGR_FG_EXT      = 16'd38;
  localparam logic [15:0] SGR_FG_DEFAULT  = 16'd39;
  localparam logic [15:0] SGR_BG_BASE     = 16'd40;
  localparam logic [15:0] SGR_BG_TOP      = 16'd47;
  localparam logic [15:0] SGR_BG_EXT      = 16'd48;
  localparam logic [15:0] SGR_BG_DEFAULT  = 16'd49;
  localparam logic [15:0] SEL_RGB         = 16'd2;
  localparam logic [15:0] SEL_PALETTE     = 16'd5;

  // style bit positions
  localparam int ST_BOLD      = 0;
  localparam int ST_ITALIC    = 1;
  localparam int ST_UNDERLINE = 2;
  localparam int ST_STRIKE    = 3;
  localparam int ST_BLINK     = 4;
  localparam int ST_INVERSE   = 5;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEL,
    PH_PAL,
    PH_RGB
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] basic;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  typedef struct packed {
    colour_t    fg;
    colour_t    bg;
    logic [5:0] style;
  } pen_t;

  typedef struct packed {
    pen_t        pen;
    phase_t      phase;
    logic        target;
    logic [15:0] buf0;
    logic [15:0] buf1;
    logic [1:0]  count;
  } sgr_state_t;

  // one parameter through the rules
  function automatic sgr_state_t feed(sgr_state_t s, logic [15:0] p);
    sgr_state_t n;
    colour_t    col;
    n   = s;
    col = s.target ? s.pen.bg : s.pen.fg;
    case (s.phase)
      PH_SEL: begin
        if (p == SEL_RGB) begin
          n.phase = PH_RGB;
          n.count = 2'd0;
        end else if (p == SEL_PALETTE) begin
          n.phase = PH_PAL;
        end else begin
          n.phase = PH_IDLE;
        end
      end
      PH_PAL: begin
        col.kind = KIND_PALETTE;
        col.red  = p[7:0];
        n.phase  = PH_IDLE;
        if (s.target) n.pen.bg = col;
        else          n.pen.fg = col;
      end
      PH_RGB: begin
        if (s.count < 2'd2) begin
          if (s.count[0]) n.buf1 = p;
          else            n.buf0 = p;
          n.count = s.count + 2'd1;
        end else begin
          col.kind  = KIND_RGB;
          col.red   = s.buf0[7:0];
          col.green = s.buf1[7:0];
          col.blue  = p[7:0];
          n.phase   = PH_IDLE;
          n.count   = 2'd0;
          if (s.target) n.pen.bg = col;
          else          n.pen.fg = col;
        end
      end
      default: begin
        case (p)
          SGR_RESET:      n.pen = '0;
          SGR_BOLD:       n.pen.style[ST_BOLD] = 1'b1;
          SGR_ITALIC:     n.pen.style[ST_ITALIC] = 1'b1;
          SGR_UNDERLINE:  n.pen.style[ST_UNDERLINE] = 1'b1;
          SGR_BLINK:      n.pen.style[ST_BLINK] = 1'b1;
          SGR_INVERSE:    n.pen.style[ST_INVERSE] = 1'b1;
          SGR_STRIKE:     n.pen.style[ST_STRIKE] = 1'b1;
          SGR_NO_BOLD_A,
          SGR_NO_BOLD_B:  n.pen.style[ST_BOLD] = 1'b0;
          SGR_NO_ITALIC:  n.pen.style[ST_ITALIC] = 1'b0;
          SGR_NO_UNDERL:  n.pen.style[ST_UNDERLINE] = 1'b0;
          SGR_NO_BLINK:   n.pen.style[ST_BLINK] = 1'b0;
          SGR_NO_INVERSE: n.pen.style[ST_INVERSE] = 1'b0;
          SGR_FG_EXT: begin
            n.target = 1'b0;
            n.phase  = PH_SEL;
          end
          SGR_BG_EXT: begin
            n.target = 1'b1;
            n.phase  = PH_SEL;
          end
          SGR_FG_DEFAULT: n.pen.fg.kind = KIND_DEFAULT;
          SGR_BG_DEFAULT: n.pen.bg.kind = KIND_DEFAULT;
          default: begin
            if (p inside {[SGR_FG_BASE:SGR_FG_TOP]}) begin
              n.pen.fg.kind  = KIND_BASIC;
              n.pen.fg.basic = p[2:0] - SGR_FG_BASE[2:0];
            end else if (p inside {[SGR_BG_BASE:SGR_BG_TOP]}) begin
              n.pen.bg.kind  = KIND_BASIC;
              n.pen.bg.basic = p[2:0] - SGR_BG_BASE[2:0];
            end
          end
        endcase
      end
    endcase
    return n;
  endfunction

  // colour fields as shown, lowest first: kind, basic, red, green, blue
  function automatic logic [28:0] emit_colour(colour_t c);
    logic [2:0] basic;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    basic = (c.kind == KIND_BASIC) ? c.basic : 3'd0;
    red   = (c.kind == KIND_PALETTE || c.kind == KIND_RGB) ? c.red : 8'd0;
    green = (c.kind == KIND_RGB) ? c.green : 8'd0;
    blue  = (c.kind == KIND_RGB) ? c.blue : 8'd0;
    return {blue, green, red, basic, c.kind};
  endfunction

endpackage

// ===== hdl/sgrp_next.sv =====
// sgr pen attribute parser: next state for one parameter, including the replay
// of buffered rgb components at the end of a sequence
// depends on sgrp_pkg
module sgrp_next
  import sgrp_pkg::*;
(
  input  sgr_state_t        cur,
  input  logic [PARAM_W-1:0] param,
  input  logic              last,
  output sgr_state_t        nxt
);

  sgr_state_t s0;
  sgr_state_t s1;
  sgr_state_t s2;
  sgr_state_t s3;

  always_comb begin
    s0 = feed(cur, param);
    s1 = s0;
    s1.phase = PH_IDLE;
    s1.count = 2'd0;
    s2 = feed(s1, s0.buf0);
    s3 = (s0.count > 2'd1) ? feed(s2, s0.buf1) : s2;
    nxt = s0;
    if (last) begin
      if (s0.phase == PH_RGB && s0.count != 2'd0) nxt = s3;
      nxt.phase = PH_IDLE;
      nxt.count = 2'd0;
    end
  end

endmodule

// ===== hdl/sgr_pen_attribute_parser_core.sv =====
// sgr pen attribute parser top level: parameter stream in, pen stream out
// depends on sgrp_pkg and sgrp_next
//
//   channel | dir | tdata                 | tlast
//   in_     | in  | param[15:0]           | last of sequence
//   out_    | out | pen, 64 bits          | -
//
// one item per cycle while in_tready is high; each accepted parameter gives its pen in the next cycle
// the pen state and the result register update in the same edge that takes an item
// in_tready falls only while a result waits and out_tready is low
// reset clears the pen, the extended colour state and the result valid
module sgr_pen_attribute_parser_core
  import sgrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [PARAM_W-1:0] in_tdata,   // param[15:0]
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  // fg_kind[1:0] fg_basic[4:2] fg_red[12:5] fg_green[20:13] fg_blue[28:21]
  // bg_kind[30:29] bg_basic[33:31] bg_red[41:34] bg_green[49:42]
  // bg_blue[57:50] style_bits[63:58]
  output logic [OUT_W-1:0]   out_tdata
);

  sgr_state_t       state_r;
  sgr_state_t       state_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  sgrp_next u_next (
    .cur   (state_r),
    .param (in_tdata),
    .last  (in_tlast),
    .nxt   (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {state_nxt.pen.style, emit_colour(state_nxt.pen.bg),
                     emit_colour(state_nxt.pen.fg)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/sgrp_checker.sv =====
// sgr pen attribute parser: port-level checks, bound to the top level
// depends on sgrp_pkg and sgr_pen_attribute_parser_core
module sgrp_props
  import sgrp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item gave no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item taken while result waits");

  a_fg_default_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_DEFAULT |-> out_tdata[28:2] == 27'd0)
    else $error("default foreground shows stale fields");

  a_bg_basic_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:29] == KIND_BASIC |-> out_tdata[57:34] == 24'd0)
    else $error("basic background shows stale components");

endmodule

bind sgr_pen_attribute_parser_core sgrp_props u_sgrp_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
